### rtl/klds_pkg.sv
// ----------------------------------------------------------------------------
// klds_pkg
// shared types and constants of the key-learning diagnostic sequencer
// ----------------------------------------------------------------------------
package klds_pkg;

  typedef struct packed {
    logic       frame_ready;
    logic       tester_busy;
    logic [7:0] rx_b1;
    logic [7:0] rx_b2;
    logic [7:0] rx_b3;
    logic [7:0] rx_b4;
  } frame_t;

  typedef struct packed {
    logic [10:0] tx_ident;
    logic [3:0]  tx_len;
    logic [7:0]  tx_service;
    logic [7:0]  tx_sub_hi;
    logic [7:0]  tx_sub_lo;
    logic [7:0]  tx_arg;
    logic [1:0]  beep_pulses;
    logic        blink_enable;
    logic        store_uses;
    logic [7:0]  uses_to_store;
    logic [3:0]  step_now;
  } result_t;

  // configuration register indexes
  localparam logic CFG_USE_COUNT = 1'b0;
  localparam logic CFG_USE_LIMIT = 1'b1;

  localparam logic [7:0] USE_COUNT_RESET = 8'd0;
  localparam logic [7:0] USE_LIMIT_RESET = 8'd8;

  // dialogue steps
  localparam logic [3:0] ST_READ_COUNT = 4'd1;
  localparam logic [3:0] ST_WAIT_IN    = 4'd2;
  localparam logic [3:0] ST_WAIT_OUT   = 4'd3;
  localparam logic [3:0] ST_KEY_TYPE   = 4'd4;
  localparam logic [3:0] ST_SESSION    = 4'd5;
  localparam logic [3:0] ST_SECURITY   = 4'd6;
  localparam logic [3:0] ST_RECHECK    = 4'd7;
  localparam logic [3:0] ST_ERASE      = 4'd10;
  localparam logic [3:0] ST_ERASE_CHK  = 4'd11;
  localparam logic [3:0] ST_SVC_MODE   = 4'd12;
  localparam logic [3:0] ST_COUNT_KEYS = 4'd13;
  localparam logic [3:0] ST_DONE       = 4'd14;

  localparam logic [10:0] IDENT_MAIN = 11'h7E0;
  localparam logic [10:0] IDENT_ALT  = 11'h720;

  localparam logic [7:0] SVC_READ_PID  = 8'h22;
  localparam logic [7:0] SVC_SESSION   = 8'h10;
  localparam logic [7:0] SVC_ROUTINE   = 8'hB1;
  localparam logic [7:0] POS_OFFSET    = 8'h40;
  localparam logic [7:0] NEG_REPLY     = 8'h7F;
  localparam logic [7:0] SESSION_REPLY = 8'h50;

  localparam logic [7:0] PID_HI_KEYS   = 8'hC1;
  localparam logic [7:0] PID_KEY_COUNT = 8'h04;
  localparam logic [7:0] PID_KEY_STAT  = 8'h24;
  localparam logic [7:0] PID_KEY_TYPE  = 8'h15;
  localparam logic [7:0] SUB_SERVICE   = 8'h87;
  localparam logic [7:0] RT_SEC_HI     = 8'h01;
  localparam logic [7:0] RT_SEC_LO     = 8'h9C;
  localparam logic [7:0] RT_ERASE_HI   = 8'h00;
  localparam logic [7:0] RT_ERASE_LO   = 8'h39;
  localparam logic [7:0] RT_MODE_HI    = 8'hF0;
  localparam logic [7:0] RT_MODE_LO    = 8'h10;

  localparam logic [7:0] KEY_STAT_BIT  = 8'h20;
  localparam logic [7:0] TYPE_RELEARN  = 8'h33;
  localparam logic [7:0] TYPE_OEM      = 8'h55;
  localparam logic [7:0] TYPE_ERASE    = 8'hAA;
  localparam logic [7:0] COUNT_ZERO    = 8'h00;
  localparam logic [7:0] COUNT_ONE     = 8'h01;
  localparam logic [7:0] COUNT_TWO     = 8'h02;

endpackage

### rtl/klds_front.sv
// ----------------------------------------------------------------------------
// klds_front
// accepts frames, builds the request of the current step and advances state
// ----------------------------------------------------------------------------
module klds_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             accept,
  input  klds_pkg::frame_t frame,
  output logic             res_valid,
  output klds_pkg::result_t res
);

  logic [7:0] use_count;
  logic [7:0] use_limit;
  logic [3:0] step;
  logic [3:0] step_next;
  logic [1:0] keys_done;
  logic [1:0] keys_done_next;
  logic       use_alt_ident;
  logic       use_alt_ident_next;
  logic       blink_on;
  logic       blink_on_next;

  logic       has_req;
  logic       live;
  logic       ok;
  logic [3:0] len;
  logic [7:0] svc;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [7:0] arg;
  logic [1:0] beeps;
  logic       store;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_count <= klds_pkg::USE_COUNT_RESET;
      use_limit <= klds_pkg::USE_LIMIT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == klds_pkg::CFG_USE_COUNT) begin
        use_count <= cfg_data;
      end else begin
        use_limit <= cfg_data;
      end
    end
  end

  // request of the current step
  always_comb begin
    has_req = 1'b1;
    len     = 4'd3;
    svc     = klds_pkg::SVC_READ_PID;
    hi      = klds_pkg::PID_HI_KEYS;
    lo      = klds_pkg::PID_KEY_COUNT;
    arg     = 8'd0;
    case (step)
      klds_pkg::ST_READ_COUNT, klds_pkg::ST_ERASE_CHK, klds_pkg::ST_COUNT_KEYS: begin
        lo = klds_pkg::PID_KEY_COUNT;
      end
      klds_pkg::ST_WAIT_IN, klds_pkg::ST_WAIT_OUT: begin
        lo = klds_pkg::PID_KEY_STAT;
      end
      klds_pkg::ST_KEY_TYPE, klds_pkg::ST_RECHECK: begin
        lo = klds_pkg::PID_KEY_TYPE;
      end
      klds_pkg::ST_SESSION: begin
        len = 4'd2;
        svc = klds_pkg::SVC_SESSION;
        hi  = klds_pkg::SUB_SERVICE;
        lo  = 8'd0;
      end
      klds_pkg::ST_SECURITY: begin
        svc = klds_pkg::SVC_ROUTINE;
        hi  = klds_pkg::RT_SEC_HI;
        lo  = klds_pkg::RT_SEC_LO;
      end
      klds_pkg::ST_ERASE: begin
        len = 4'd4;
        svc = klds_pkg::SVC_ROUTINE;
        hi  = klds_pkg::RT_ERASE_HI;
        lo  = klds_pkg::RT_ERASE_LO;
        arg = 8'd1;
      end
      klds_pkg::ST_SVC_MODE: begin
        len = 4'd4;
        svc = klds_pkg::SVC_ROUTINE;
        hi  = klds_pkg::RT_MODE_HI;
        lo  = klds_pkg::RT_MODE_LO;
      end
      default: begin
        has_req = 1'b0;
      end
    endcase
  end

  assign live = frame.frame_ready && !frame.tester_busy && (use_count <= use_limit) &&
                has_req;
  assign ok   = (frame.rx_b1 == 8'(svc + klds_pkg::POS_OFFSET)) && (frame.rx_b2 == hi) &&
                (frame.rx_b3 == lo);

  // check of the latest received frame
  always_comb begin
    step_next          = step;
    keys_done_next     = keys_done;
    use_alt_ident_next = use_alt_ident;
    blink_on_next      = blink_on;
    beeps              = 2'd0;
    store              = 1'b0;
    case (step)
      klds_pkg::ST_READ_COUNT: begin
        if (frame.rx_b1 == klds_pkg::NEG_REPLY) begin
          use_alt_ident_next = 1'b1;
        end else if (ok) begin
          step_next = klds_pkg::ST_WAIT_IN;
        end
      end
      klds_pkg::ST_WAIT_IN: begin
        if (ok && |(frame.rx_b4 & klds_pkg::KEY_STAT_BIT)) begin
          step_next = klds_pkg::ST_WAIT_OUT;
          beeps     = 2'd1;
        end
      end
      klds_pkg::ST_WAIT_OUT: begin
        if (ok && !(|(frame.rx_b4 & klds_pkg::KEY_STAT_BIT))) begin
          step_next = klds_pkg::ST_KEY_TYPE;
          beeps     = 2'd1;
        end
      end
      klds_pkg::ST_KEY_TYPE: begin
        if (ok) begin
          if (frame.rx_b4 == klds_pkg::TYPE_RELEARN) begin
            step_next = klds_pkg::ST_SESSION;
          end else if (frame.rx_b4 == klds_pkg::TYPE_OEM) begin
            step_next = klds_pkg::ST_RECHECK;
          end else if (frame.rx_b4 == klds_pkg::TYPE_ERASE) begin
            step_next     = klds_pkg::ST_ERASE;
            blink_on_next = 1'b0;
            beeps         = 2'd2;
          end
        end
      end
      klds_pkg::ST_SESSION: begin
        if ((frame.rx_b1 == klds_pkg::SESSION_REPLY && frame.rx_b2 == klds_pkg::SUB_SERVICE) ||
            (frame.rx_b1 == klds_pkg::NEG_REPLY && frame.rx_b2 == klds_pkg::SVC_SESSION)) begin
          step_next = klds_pkg::ST_SECURITY;
        end
      end
      klds_pkg::ST_SECURITY: begin
        if (ok) begin
          step_next     = klds_pkg::ST_RECHECK;
          beeps         = 2'd1;
          blink_on_next = 1'b1;
        end
      end
      klds_pkg::ST_RECHECK: begin
        if (ok) begin
          if (frame.rx_b4 == klds_pkg::TYPE_RELEARN) begin
            step_next = klds_pkg::ST_WAIT_IN;
          end else if (frame.rx_b4 == klds_pkg::TYPE_ERASE) begin
            step_next = klds_pkg::ST_ERASE;
          end
        end
      end
      klds_pkg::ST_ERASE: begin
        if (ok) begin
          step_next = klds_pkg::ST_ERASE_CHK;
        end
      end
      klds_pkg::ST_ERASE_CHK: begin
        if (ok && frame.rx_b4 == klds_pkg::COUNT_ZERO) begin
          step_next = klds_pkg::ST_SVC_MODE;
        end
      end
      klds_pkg::ST_SVC_MODE: begin
        if (ok) begin
          step_next     = klds_pkg::ST_COUNT_KEYS;
          blink_on_next = 1'b0;
          beeps         = 2'd2;
        end
      end
      klds_pkg::ST_COUNT_KEYS: begin
        if (ok) begin
          if (frame.rx_b4 == klds_pkg::COUNT_ONE && keys_done == 2'd0) begin
            keys_done_next = 2'd1;
            beeps          = 2'd1;
          end else if (frame.rx_b4 == klds_pkg::COUNT_TWO && keys_done == 2'd1) begin
            keys_done_next = 2'd2;
            step_next      = klds_pkg::ST_DONE;
            beeps          = 2'd3;
            store          = 1'b1;
          end
        end
      end
      default: begin
        step_next = step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= klds_pkg::ST_READ_COUNT;
      keys_done     <= 2'd0;
      use_alt_ident <= 1'b0;
      blink_on      <= 1'b1;
    end else if (accept && live) begin
      step          <= step_next;
      keys_done     <= keys_done_next;
      use_alt_ident <= use_alt_ident_next;
      blink_on      <= blink_on_next;
    end
  end

  assign res_valid = accept && live;

  always_comb begin
    res.tx_ident      = use_alt_ident ? klds_pkg::IDENT_ALT : klds_pkg::IDENT_MAIN;
    res.tx_len        = len;
    res.tx_service    = svc;
    res.tx_sub_hi     = hi;
    res.tx_sub_lo     = lo;
    res.tx_arg        = arg;
    res.beep_pulses   = beeps;
    res.blink_enable  = blink_on_next;
    res.store_uses    = store;
    res.uses_to_store = use_count + 8'd1;
    res.step_now      = step_next;
  end

`ifndef SYNTHESIS
  a_step_legal: assert property (@(posedge clk) disable iff (rst)
    step == klds_pkg::ST_READ_COUNT || step == klds_pkg::ST_WAIT_IN ||
    step == klds_pkg::ST_WAIT_OUT || step == klds_pkg::ST_KEY_TYPE ||
    step == klds_pkg::ST_SESSION || step == klds_pkg::ST_SECURITY ||
    step == klds_pkg::ST_RECHECK || step == klds_pkg::ST_ERASE ||
    step == klds_pkg::ST_ERASE_CHK || step == klds_pkg::ST_SVC_MODE ||
    step == klds_pkg::ST_COUNT_KEYS || step == klds_pkg::ST_DONE)
    else $error("step left the sequence");
  a_keys_done: assert property (@(posedge clk) disable iff (rst)
    (keys_done == 2'd2) |-> (step == klds_pkg::ST_DONE))
    else $error("second key counted without finishing");
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && live) |=> $stable(step) && $stable(keys_done) && $stable(use_alt_ident))
    else $error("state moved without a transaction");
  a_store_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.store_uses |=> step == klds_pkg::ST_DONE)
    else $error("use store without finishing");
`endif

endmodule

### rtl/klds_queue.sv
// ----------------------------------------------------------------------------
// klds_queue
// short result queue between the request front and the output stage
// ----------------------------------------------------------------------------
module klds_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  klds_pkg::result_t wr_data,
  output logic              full,
  input  logic              rd,
  output logic              avail,
  output klds_pkg::result_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  klds_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign avail   = (count != '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && avail;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("write into a full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");
  a_empty_after: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(1)) && do_rd && !do_wr |=> !avail)
    else $error("queue not empty after last read");
`endif

endmodule

### rtl/klds_back.sv
// ----------------------------------------------------------------------------
// klds_back
// output stage that presents the oldest result to the consumer
// ----------------------------------------------------------------------------
module klds_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_avail,
  input  klds_pkg::result_t q_data,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output klds_pkg::result_t result
);

  logic out_valid;
  logic load;

  assign load  = q_avail && (!out_valid || pop);
  assign q_rd  = load;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= q_data;
    end
  end

`ifndef SYNTHESIS
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(result))
    else $error("waiting result changed");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && pop && !q_avail |=> !out_valid)
    else $error("output stage kept a taken result");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    q_avail && !out_valid |=> out_valid)
    else $error("output stage missed a waiting result");
`endif

endmodule

### rtl/key_learn_diag_sequencer_top.sv
// ----------------------------------------------------------------------------
// key_learn_diag_sequencer_top
// key-learning diagnostic dialogue sequencer
//
//   channel   handshake           payload
//   frame     push / full         klds_pkg::frame_t
//   result    pop / empty         klds_pkg::result_t
//   config    cfg_write           cfg_index, cfg_data
//
// one frame is accepted per cycle while full is low; the request and the state update are
// done in the front in the cycle of the transaction.
// a result passes through the queue, then the output register, before it
// is on the result ports, and it is held there until pop; zero or one
// result per frame.
// full rises when the result queue holds QUEUE_DEPTH results; the output
// register stalls on its own while pop is low.
// synchronous reset: step 1, no keys, main identifier, blink on, queue empty.
// ----------------------------------------------------------------------------
module key_learn_diag_sequencer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              push,
  output logic              full,
  input  klds_pkg::frame_t  frame,
  output logic              empty,
  input  logic              pop,
  output klds_pkg::result_t result
);

  logic              accept;
  logic              res_valid;
  klds_pkg::result_t res;
  logic              q_avail;
  logic              q_rd;
  klds_pkg::result_t q_data;

  assign accept = push && !full;

  klds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .frame     (frame),
    .res_valid (res_valid),
    .res       (res)
  );

  klds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_valid),
    .wr_data (res),
    .full    (full),
    .rd      (q_rd),
    .avail   (q_avail),
    .rd_data (q_data)
  );

  klds_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

### tb/klds_reply_checker.sv
// ----------------------------------------------------------------------------
// klds_reply_checker
// tracks the dialogue on its own and compares every popped result in order
// ----------------------------------------------------------------------------
module klds_reply_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              push,
  input  logic              full,
  input  klds_pkg::frame_t  frame,
  input  logic              empty,
  input  logic              pop,
  input  klds_pkg::result_t result,
  output int                pending,
  output int                fail_count,
  output logic [3:0]        cur_step
);

  logic [3:0]        lrn_step;
  logic [1:0]        keys_done;
  logic              alt_ident;
  logic              blink_on;
  logic [7:0]        uses;
  logic [7:0]        use_limit;
  klds_pkg::result_t pending_requests[$];
  int                errors = 0;

  function automatic bit predict_request(input klds_pkg::frame_t f,
                                         output klds_pkg::result_t r);
    logic [3:0] len;
    logic [7:0] svc;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] arg;
    logic [1:0] beeps;
    logic       store;
    logic       ok;
    r = '0;
    beeps = 2'd0;
    store = 1'b0;
    arg = 8'h00;
    if (!f.frame_ready || f.tester_busy || uses > use_limit) return 1'b0;
    case (lrn_step)
      klds_pkg::ST_READ_COUNT, klds_pkg::ST_ERASE_CHK, klds_pkg::ST_COUNT_KEYS: begin
        len = 4'd3; svc = klds_pkg::SVC_READ_PID; hi = klds_pkg::PID_HI_KEYS;
        lo = klds_pkg::PID_KEY_COUNT;
      end
      klds_pkg::ST_WAIT_IN, klds_pkg::ST_WAIT_OUT: begin
        len = 4'd3; svc = klds_pkg::SVC_READ_PID; hi = klds_pkg::PID_HI_KEYS;
        lo = klds_pkg::PID_KEY_STAT;
      end
      klds_pkg::ST_KEY_TYPE, klds_pkg::ST_RECHECK: begin
        len = 4'd3; svc = klds_pkg::SVC_READ_PID; hi = klds_pkg::PID_HI_KEYS;
        lo = klds_pkg::PID_KEY_TYPE;
      end
      klds_pkg::ST_SESSION: begin
        len = 4'd2; svc = klds_pkg::SVC_SESSION; hi = klds_pkg::SUB_SERVICE; lo = 8'h00;
      end
      klds_pkg::ST_SECURITY: begin
        len = 4'd3; svc = klds_pkg::SVC_ROUTINE; hi = klds_pkg::RT_SEC_HI;
        lo = klds_pkg::RT_SEC_LO;
      end
      klds_pkg::ST_ERASE: begin
        len = 4'd4; svc = klds_pkg::SVC_ROUTINE; hi = klds_pkg::RT_ERASE_HI;
        lo = klds_pkg::RT_ERASE_LO; arg = 8'h01;
      end
      klds_pkg::ST_SVC_MODE: begin
        len = 4'd4; svc = klds_pkg::SVC_ROUTINE; hi = klds_pkg::RT_MODE_HI;
        lo = klds_pkg::RT_MODE_LO;
      end
      default: return 1'b0;
    endcase

    r.tx_ident = alt_ident ? klds_pkg::IDENT_ALT : klds_pkg::IDENT_MAIN;
    ok = (f.rx_b1 == 8'(svc + klds_pkg::POS_OFFSET)) && (f.rx_b2 == hi) && (f.rx_b3 == lo);

    case (lrn_step)
      klds_pkg::ST_READ_COUNT: begin
        if (f.rx_b1 == klds_pkg::NEG_REPLY) alt_ident = 1'b1;
        else if (ok) lrn_step = klds_pkg::ST_WAIT_IN;
      end
      klds_pkg::ST_WAIT_IN: begin
        if (ok && (f.rx_b4 & klds_pkg::KEY_STAT_BIT) != 8'h00) begin
          lrn_step = klds_pkg::ST_WAIT_OUT; beeps = 2'd1;
        end
      end
      klds_pkg::ST_WAIT_OUT: begin
        if (ok && (f.rx_b4 & klds_pkg::KEY_STAT_BIT) == 8'h00) begin
          lrn_step = klds_pkg::ST_KEY_TYPE; beeps = 2'd1;
        end
      end
      klds_pkg::ST_KEY_TYPE: begin
        if (ok) begin
          if (f.rx_b4 == klds_pkg::TYPE_RELEARN) lrn_step = klds_pkg::ST_SESSION;
          else if (f.rx_b4 == klds_pkg::TYPE_OEM) lrn_step = klds_pkg::ST_RECHECK;
          else if (f.rx_b4 == klds_pkg::TYPE_ERASE) begin
            lrn_step = klds_pkg::ST_ERASE; blink_on = 1'b0; beeps = 2'd2;
          end
        end
      end
      klds_pkg::ST_SESSION: begin
        if ((f.rx_b1 == klds_pkg::SESSION_REPLY && f.rx_b2 == klds_pkg::SUB_SERVICE) ||
            (f.rx_b1 == klds_pkg::NEG_REPLY && f.rx_b2 == klds_pkg::SVC_SESSION))
          lrn_step = klds_pkg::ST_SECURITY;
      end
      klds_pkg::ST_SECURITY: begin
        if (ok) begin
          lrn_step = klds_pkg::ST_RECHECK; beeps = 2'd1; blink_on = 1'b1;
        end
      end
      klds_pkg::ST_RECHECK: begin
        if (ok) begin
          if (f.rx_b4 == klds_pkg::TYPE_RELEARN) lrn_step = klds_pkg::ST_WAIT_IN;
          else if (f.rx_b4 == klds_pkg::TYPE_ERASE) lrn_step = klds_pkg::ST_ERASE;
        end
      end
      klds_pkg::ST_ERASE: begin
        if (ok) lrn_step = klds_pkg::ST_ERASE_CHK;
      end
      klds_pkg::ST_ERASE_CHK: begin
        if (ok && f.rx_b4 == klds_pkg::COUNT_ZERO) lrn_step = klds_pkg::ST_SVC_MODE;
      end
      klds_pkg::ST_SVC_MODE: begin
        if (ok) begin
          lrn_step = klds_pkg::ST_COUNT_KEYS; blink_on = 1'b0; beeps = 2'd2;
        end
      end
      default: begin
        // extra key reports fall through both branches
        if (ok) begin
          if (f.rx_b4 == klds_pkg::COUNT_ONE && keys_done == 2'd0) begin
            keys_done = 2'd1; beeps = 2'd1;
          end else if (f.rx_b4 == klds_pkg::COUNT_TWO && keys_done == 2'd1) begin
            keys_done = 2'd2; lrn_step = klds_pkg::ST_DONE; beeps = 2'd3; store = 1'b1;
          end
        end
      end
    endcase

    r.tx_len = len;
    r.tx_service = svc;
    r.tx_sub_hi = hi;
    r.tx_sub_lo = lo;
    r.tx_arg = arg;
    r.beep_pulses = beeps;
    r.blink_enable = blink_on;
    r.store_uses = store;
    r.uses_to_store = uses + 8'd1;
    r.step_now = lrn_step;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    klds_pkg::result_t want;
    klds_pkg::result_t next_req;
    if (rst) begin
      lrn_step = klds_pkg::ST_READ_COUNT;
      keys_done = 2'd0;
      alt_ident = 1'b0;
      blink_on = 1'b1;
      uses = klds_pkg::USE_COUNT_RESET;
      use_limit = klds_pkg::USE_LIMIT_RESET;
      pending_requests.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          klds_pkg::CFG_USE_COUNT: uses = cfg_data;
          klds_pkg::CFG_USE_LIMIT: use_limit = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pending_requests.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no outstanding frame: %h", $time, result);
        end else begin
          want = pending_requests.pop_front();
          if (result !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch expected %h", $time, want);
              $display("%0t:          actual   %h", $time, result);
            end
          end
        end
      end
      if (push && !full) begin
        if (predict_request(frame, next_req)) pending_requests.push_back(next_req);
      end
    end
    pending <= pending_requests.size();
    fail_count <= errors;
    cur_step <= lrn_step;
  end

endmodule

### tb/tb_key_learn_diag_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_key_learn_diag_sequencer_top
// directed and random frame stimulus for the key-learning sequencer
// ----------------------------------------------------------------------------
module tb_key_learn_diag_sequencer_top;

  localparam logic [7:0] READ_OK    = klds_pkg::SVC_READ_PID + klds_pkg::POS_OFFSET;
  localparam logic [7:0] ROUTINE_OK = klds_pkg::SVC_ROUTINE + klds_pkg::POS_OFFSET;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = klds_pkg::CFG_USE_COUNT;
  logic [7:0]        cfg_data = 8'h00;
  logic              push = 1'b0;
  logic              full;
  klds_pkg::frame_t  frame = '0;
  logic              empty;
  logic              pop = 1'b0;
  klds_pkg::result_t result;
  int                pending;
  int                fail_count;
  logic [3:0]        cur_step;
  bit                steady = 1'b0;
  bit                allow_end = 1'b0;

  key_learn_diag_sequencer_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .frame(frame),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  klds_reply_checker i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .frame(frame),
    .empty(empty),
    .pop(pop),
    .result(result),
    .pending(pending),
    .fail_count(fail_count),
    .cur_step(cur_step)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= 36);
  end

  function automatic klds_pkg::frame_t fr(input logic rdy, input logic tst,
                                          input logic [7:0] b1, b2, b3, b4);
    klds_pkg::frame_t f;
    f.frame_ready = rdy;
    f.tester_busy = tst;
    f.rx_b1 = b1;
    f.rx_b2 = b2;
    f.rx_b3 = b3;
    f.rx_b4 = b4;
    return f;
  endfunction

  // mostly a positive reply to the request of the given step
  function automatic klds_pkg::frame_t reply_for(input logic [3:0] stp, input bit late);
    klds_pkg::frame_t f;
    logic [7:0]       filler;
    int               pick;
    filler = 8'($urandom_range(255));
    pick = $urandom_range(7);
    f = fr(1'b1, 1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
           8'($urandom_range(255)), 8'($urandom_range(255)));
    case (stp)
      klds_pkg::ST_READ_COUNT: begin
        if ($urandom_range(19) == 0) f.rx_b1 = klds_pkg::NEG_REPLY;
        else {f.rx_b1, f.rx_b2, f.rx_b3} =
               {READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_COUNT};
      end
      klds_pkg::ST_WAIT_IN: begin
        {f.rx_b1, f.rx_b2, f.rx_b3} = {READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT};
        f.rx_b4 = (pick < 6) ? (filler | klds_pkg::KEY_STAT_BIT) : filler;
      end
      klds_pkg::ST_WAIT_OUT: begin
        {f.rx_b1, f.rx_b2, f.rx_b3} = {READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT};
        f.rx_b4 = (pick < 6) ? (filler & ~klds_pkg::KEY_STAT_BIT) : filler;
      end
      klds_pkg::ST_KEY_TYPE, klds_pkg::ST_RECHECK: begin
        {f.rx_b1, f.rx_b2, f.rx_b3} = {READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_TYPE};
        if (pick < 3) f.rx_b4 = klds_pkg::TYPE_RELEARN;
        else if (pick < 6) f.rx_b4 = klds_pkg::TYPE_OEM;
        else if (pick == 6 && late) f.rx_b4 = klds_pkg::TYPE_ERASE;
        else if (filler == klds_pkg::TYPE_ERASE) f.rx_b4 = klds_pkg::COUNT_ZERO;
        else f.rx_b4 = filler;
      end
      klds_pkg::ST_SESSION: begin
        if (pick < 4) {f.rx_b1, f.rx_b2} = {klds_pkg::SESSION_REPLY, klds_pkg::SUB_SERVICE};
        else {f.rx_b1, f.rx_b2} = {klds_pkg::NEG_REPLY, klds_pkg::SVC_SESSION};
      end
      klds_pkg::ST_SECURITY:
        {f.rx_b1, f.rx_b2, f.rx_b3} = {ROUTINE_OK, klds_pkg::RT_SEC_HI, klds_pkg::RT_SEC_LO};
      klds_pkg::ST_ERASE:
        {f.rx_b1, f.rx_b2, f.rx_b3} = {ROUTINE_OK, klds_pkg::RT_ERASE_HI, klds_pkg::RT_ERASE_LO};
      klds_pkg::ST_ERASE_CHK: begin
        {f.rx_b1, f.rx_b2, f.rx_b3} = {READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_COUNT};
        f.rx_b4 = (pick < 4) ? klds_pkg::COUNT_ZERO : filler;
      end
      klds_pkg::ST_SVC_MODE:
        {f.rx_b1, f.rx_b2, f.rx_b3} = {ROUTINE_OK, klds_pkg::RT_MODE_HI, klds_pkg::RT_MODE_LO};
      klds_pkg::ST_COUNT_KEYS: begin
        {f.rx_b1, f.rx_b2, f.rx_b3} = {READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_COUNT};
        case (pick % 4)
          0: f.rx_b4 = klds_pkg::COUNT_ONE;
          1: f.rx_b4 = klds_pkg::COUNT_TWO;
          2: f.rx_b4 = klds_pkg::COUNT_ZERO;
          default: f.rx_b4 = filler;
        endcase
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic klds_pkg::frame_t random_frame();
    klds_pkg::frame_t f;
    int               r;
    r = $urandom_range(99);
    if (r < 75) begin
      f = reply_for(cur_step, allow_end);
    end else if (r < 85) begin
      f = reply_for(4'($urandom_range(15)), allow_end);
    end else begin
      f = fr(1'b1, 1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(255)), 8'($urandom_range(255)));
      f.frame_ready = ($urandom_range(3) != 0);
      f.tester_busy = ($urandom_range(3) == 0);
    end
    return f;
  endfunction

  task automatic send_frame(input klds_pkg::frame_t f);
    while (!steady && $urandom_range(99) < 36) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    frame <= f;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] count_val, input logic [7:0] limit_val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= klds_pkg::CFG_USE_COUNT;
    cfg_data <= count_val;
    @(posedge clk);
    cfg_index <= klds_pkg::CFG_USE_LIMIT;
    cfg_data <= limit_val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_frames(input int count);
    klds_pkg::frame_t f;
    int               n;
    n = 0;
    while (n < count) begin
      f = random_frame();
      if (f.frame_ready && !f.tester_busy) n++;
      send_frame(f);
    end
  endtask

  initial begin
    logic [7:0] lim;
    int         n;
    int         tail;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk through the first part of the dialogue
    send_frame(fr(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(fr(1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(fr(1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(fr(1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(fr(1'b1, 1'b0, klds_pkg::NEG_REPLY, 8'h00, 8'h00, 8'h00));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_COUNT, 8'hFF));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT,
                  klds_pkg::COUNT_ZERO));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT,
                  klds_pkg::KEY_STAT_BIT));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT,
                  klds_pkg::KEY_STAT_BIT));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT, 8'hDF));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_TYPE,
                  klds_pkg::TYPE_RELEARN));
    send_frame(fr(1'b1, 1'b0, klds_pkg::NEG_REPLY, klds_pkg::SVC_SESSION, 8'h00, 8'h00));
    send_frame(fr(1'b1, 1'b0, ROUTINE_OK, klds_pkg::RT_SEC_HI, klds_pkg::RT_SEC_LO, 8'h00));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_TYPE,
                  klds_pkg::TYPE_RELEARN));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT, 8'hFF));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT, 8'h00));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_TYPE,
                  klds_pkg::TYPE_OEM));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_TYPE,
                  klds_pkg::TYPE_OEM));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_TYPE,
                  klds_pkg::TYPE_RELEARN));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT,
                  klds_pkg::KEY_STAT_BIT));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_STAT,
                  klds_pkg::COUNT_ZERO));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::PID_HI_KEYS, klds_pkg::PID_KEY_TYPE,
                  klds_pkg::TYPE_RELEARN));
    send_frame(fr(1'b1, 1'b0, klds_pkg::SESSION_REPLY, klds_pkg::SUB_SERVICE, 8'h00, 8'h00));
    send_frame(fr(1'b1, 1'b0, READ_OK, klds_pkg::RT_SEC_HI, klds_pkg::RT_SEC_LO, 8'h00));
    send_frame(fr(1'b1, 1'b0, ROUTINE_OK, klds_pkg::RT_SEC_HI, klds_pkg::RT_SEC_LO, 8'hFF));

    run_frames(250);

    write_regs(8'hFF, 8'hFF);
    steady = 1'b1;
    run_frames(250);
    steady = 1'b0;

    // use count above the limit: every transaction is dropped
    write_regs(8'd9, 8'd8);
    repeat (30) send_frame(random_frame());

    write_regs(8'h00, 8'h00);
    run_frames(250);

    repeat (3) begin
      lim = 8'($urandom_range(255));
      write_regs(8'($urandom_range(lim)), lim);
      run_frames(250);
    end

    write_regs(8'd7, klds_pkg::USE_LIMIT_RESET);
    allow_end = 1'b1;
    n = 0;
    tail = 0;
    while (tail < 20 && n < 400) begin
      send_frame(random_frame());
      n++;
      if (cur_step == klds_pkg::ST_DONE) tail++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
